### rtl/sroe_pkg.sv
// Package for the S-record object encoder: action codes, character selects,
// controller/datapath interface structs and character helper functions.
// Depends on nothing; imported by every module of the encoder.
package sroe_pkg;

    // Bytes gathered into one data record before it is flushed.
    localparam int BYTES_PER_RECORD = 16;

    // Derived widths.
    localparam int CNT_W = $clog2(BYTES_PER_RECORD + 1);
    localparam int BI_W  = (BYTES_PER_RECORD > 1) ? $clog2(BYTES_PER_RECORD) : 1;
    localparam int IDX_W = $clog2(2 * (BYTES_PER_RECORD + 5));
    localparam int KW    = IDX_W - 1;

    // Index of the final character of the header and trailer texts.
    localparam logic [IDX_W-1:0] TEXT_LAST = IDX_W'(10);

    // Action codes of the input word.
    localparam logic [2:0] ACT_DATA  = 3'd0;
    localparam logic [2:0] ACT_FIRST = 3'd1;
    localparam logic [2:0] ACT_SYNC  = 3'd2;
    localparam logic [2:0] ACT_OPEN  = 3'd3;
    localparam logic [2:0] ACT_CLOSE = 3'd4;
    localparam logic [2:0] ACT_MSG   = 3'd5;

    // ASCII codes used in the records.
    localparam logic [6:0] CH_S  = 7'h53;
    localparam logic [6:0] CH_0  = 7'h30;
    localparam logic [6:0] CH_1  = 7'h31;
    localparam logic [6:0] CH_2  = 7'h32;
    localparam logic [6:0] CH_3  = 7'h33;
    localparam logic [6:0] CH_9  = 7'h39;
    localparam logic [6:0] CH_C  = 7'h43;
    localparam logic [6:0] CH_F  = 7'h46;
    localparam logic [6:0] CH_NL = 7'h0A;
    localparam logic [6:0] CH_NUL = 7'h00;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REC_S,
        ST_REC_T,
        ST_REC_HEX,
        ST_REC_NL,
        ST_HDR,
        ST_TRL,
        ST_ERR
    } t_state;

    // Source of the next output character.
    typedef enum logic [2:0] {
        CS_S,
        CS_TYPE,
        CS_HEX,
        CS_NL,
        CS_HDR,
        CS_TRL,
        CS_ERR
    } t_csel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  capture;
        logic  start;
        logic  load;
        logic  clr_idx;
        logic  step_idx;
        logic  last;
        t_csel sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] action;
        logic       count_zero;
        logic       count_full;
        logic       hex_last;
        logic       text_last;
    } t_status;

    // Uppercase hex digit for the low four bits.
    function automatic logic [6:0] nibble_char(input logic [3:0] v);
        logic [6:0] r;
        begin
            if (v > 4'd9) begin
                r = 7'(v) + 7'd55;
            end else begin
                r = 7'(v) + 7'd48;
            end
            return r;
        end
    endfunction

    // Characters of the fixed header and trailer texts; they differ in the type digit only.
    function automatic logic [6:0] text_char(input logic [IDX_W-1:0] idx, input logic trailer);
        logic [6:0] r;
        begin
            case (idx)
                IDX_W'(0):  r = CH_S;
                IDX_W'(1):  r = trailer ? CH_9 : CH_0;
                IDX_W'(3):  r = CH_3;
                IDX_W'(8):  r = CH_F;
                IDX_W'(9):  r = CH_C;
                IDX_W'(10): r = CH_NL;
                default:    r = CH_0;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/sroe_ctrl.sv
// Controller of the S-record object encoder: sequencing state machine,
// output valid flag and the output-enable register. Uses sroe_pkg.
module sroe_ctrl
    import sroe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_enable;
    logic   w_accept;
    logic   w_out_free;
    t_cmd   w_cmd;

    // Handshake qualifiers.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && r_enable) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                case (i_status.action) inside
                    ACT_DATA, ACT_FIRST: n_state = i_status.count_full ? ST_REC_S : ST_IDLE;
                    ACT_SYNC:  n_state = i_status.count_zero ? ST_IDLE : ST_REC_S;
                    ACT_OPEN:  n_state = ST_HDR;
                    ACT_CLOSE: n_state = i_status.count_zero ? ST_TRL : ST_REC_S;
                    ACT_MSG:   n_state = ST_IDLE;
                    default:   n_state = ST_ERR;
                endcase
            end
            ST_REC_S: begin
                if (w_out_free) begin
                    n_state = ST_REC_T;
                end
            end
            ST_REC_T: begin
                if (w_out_free) begin
                    n_state = ST_REC_HEX;
                end
            end
            ST_REC_HEX: begin
                if (w_out_free && i_status.hex_last) begin
                    n_state = ST_REC_NL;
                end
            end
            ST_REC_NL: begin
                if (w_out_free) begin
                    n_state = (i_status.action == ACT_CLOSE) ? ST_TRL : ST_IDLE;
                end
            end
            ST_HDR, ST_TRL: begin
                if (w_out_free && i_status.text_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        w_cmd = '{capture: 1'b0, start: 1'b0, load: 1'b0, clr_idx: 1'b0,
                  step_idx: 1'b0, last: 1'b0, sel: CS_S};
        unique case (r_state)
            ST_IDLE: begin
                w_cmd.capture = w_accept && r_enable;
            end
            ST_DECIDE: begin
                w_cmd.clr_idx = 1'b1;
                // An empty record on sync only restarts the address.
                w_cmd.start   = (i_status.action == ACT_SYNC) && i_status.count_zero;
            end
            ST_REC_S: begin
                w_cmd.sel  = CS_S;
                w_cmd.load = w_out_free;
            end
            ST_REC_T: begin
                w_cmd.sel  = CS_TYPE;
                w_cmd.load = w_out_free;
            end
            ST_REC_HEX: begin
                w_cmd.sel      = CS_HEX;
                w_cmd.load     = w_out_free;
                w_cmd.step_idx = w_out_free;
            end
            ST_REC_NL: begin
                // On close the trailer still follows, so the new record starts after it.
                w_cmd.sel     = CS_NL;
                w_cmd.load    = w_out_free;
                w_cmd.clr_idx = w_out_free;
                w_cmd.last    = (i_status.action != ACT_CLOSE);
                w_cmd.start   = w_out_free && (i_status.action != ACT_CLOSE);
            end
            ST_HDR, ST_TRL: begin
                w_cmd.sel      = (r_state == ST_HDR) ? CS_HDR : CS_TRL;
                w_cmd.load     = w_out_free;
                w_cmd.step_idx = w_out_free;
                w_cmd.last     = i_status.text_last;
                w_cmd.start    = w_out_free && i_status.text_last;
            end
            ST_ERR: begin
                w_cmd.sel  = CS_ERR;
                w_cmd.load = w_out_free;
                w_cmd.last = 1'b1;
            end
            default: begin
                w_cmd.load = 1'b0;
            end
        endcase
    end

    // The output word stays valid until it is taken or replaced.
    always_comb begin
        if (w_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State, output valid and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
        end
    end

    // A character is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> w_out_free)
        else $error("character loaded over an untaken output word");

    // The decision state always follows an accepted word.
    a_decide_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> $past(w_accept && r_enable))
        else $error("decision without an accepted word");

    // The final character of an item returns the controller to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load && w_cmd.last) |=> (r_state == ST_IDLE))
        else $error("controller busy after the final character");

endmodule

### rtl/sroe_dp.sv
// Datapath of the S-record object encoder: record buffer, count, checksum,
// address and offset state, character index and output word. Uses sroe_pkg.
module sroe_dp
    import sroe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic [23:0] i_location,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [6:0]  o_out_char,
    output logic        o_last,
    output logic        o_error
);

    logic [7:0]       r_bytes [BYTES_PER_RECORD];
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_sum;
    logic [23:0]      r_offset;
    logic [23:0]      r_addr;
    logic             r_wide;
    logic [2:0]       r_action;
    logic [23:0]      r_loc;
    logic [IDX_W-1:0] r_idx;
    logic [6:0]       r_char;
    logic             r_last;
    logic             r_error;

    logic             w_is_data;
    logic             w_in_data;
    logic [23:0]      w_base;
    logic [23:0]      w_start_addr;
    logic [2:0]       w_addr_len;
    logic [KW-1:0]    w_k;
    logic [KW-1:0]    w_last_byte;
    logic [KW-1:0]    w_addr_pos;
    logic [KW-1:0]    w_di;
    logic [7:0]       w_total;
    logic [7:0]       w_cks;
    logic [7:0]       w_hex_byte;
    logic [6:0]       w_char;

    // Decoding of the latched and incoming actions.
    assign w_in_data  = (i_action == ACT_DATA) || (i_action == ACT_FIRST);
    assign w_is_data  = (r_action == ACT_DATA) || (r_action == ACT_FIRST);
    assign w_base     = (i_action == ACT_FIRST) ? 24'd0 : r_offset;

    // Address of the next record: the location, plus the item offset after a full record.
    assign w_start_addr = r_loc + (w_is_data ? r_offset : 24'd0);

    // Field positions within the hex part of a record.
    assign w_addr_len  = r_wide ? 3'd3 : 3'd2;
    assign w_k         = r_idx[IDX_W-1:1];
    assign w_last_byte = KW'(w_addr_len) + KW'(r_count) + KW'(1);
    assign w_addr_pos  = w_k + (r_wide ? KW'(0) : KW'(1));
    assign w_di        = w_k - KW'(w_addr_len) - KW'(1);
    assign w_total     = 8'(r_count) + 8'(w_addr_len) + 8'd1;
    assign w_cks       = 8'hFF - (r_sum + w_total);

    // Byte shown by the hex stream: count, address, data, checksum.
    always_comb begin
        if (w_k == KW'(0)) begin
            w_hex_byte = w_total;
        end else if (w_k <= KW'(w_addr_len)) begin
            case (w_addr_pos)
                KW'(1):  w_hex_byte = r_addr[23:16];
                KW'(2):  w_hex_byte = r_addr[15:8];
                default: w_hex_byte = r_addr[7:0];
            endcase
        end else if (w_k <= KW'(w_addr_len) + KW'(r_count)) begin
            w_hex_byte = r_bytes[w_di[BI_W-1:0]];
        end else begin
            w_hex_byte = w_cks;
        end
    end

    // Character selection.
    always_comb begin
        unique case (i_cmd.sel)
            CS_S:    w_char = CH_S;
            CS_TYPE: w_char = r_wide ? CH_2 : CH_1;
            CS_HEX:  w_char = nibble_char(r_idx[0] ? w_hex_byte[3:0] : w_hex_byte[7:4]);
            CS_NL:   w_char = CH_NL;
            CS_HDR:  w_char = text_char(r_idx, 1'b0);
            CS_TRL:  w_char = text_char(r_idx, 1'b1);
            default: w_char = CH_NUL;
        endcase
    end

    // Status to the controller.
    assign o_status.action     = r_action;
    assign o_status.count_zero = (r_count == CNT_W'(0));
    assign o_status.count_full = (r_count >= CNT_W'(BYTES_PER_RECORD));
    assign o_status.hex_last   = (w_k == w_last_byte) && r_idx[0];
    assign o_status.text_last  = (r_idx == TEXT_LAST);

    assign o_out_char = r_char;
    assign o_last     = r_last;
    assign o_error    = r_error;

    // Record state: a data word is absorbed on capture, a new record opened on start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= 8'd0;
            r_offset <= 24'd0;
            r_addr   <= 24'd0;
            r_wide   <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (i_cmd.capture && w_in_data) begin
                if (r_count < CNT_W'(BYTES_PER_RECORD)) begin
                    r_count  <= r_count + CNT_W'(1);
                    r_sum    <= r_sum + i_data_byte;
                    r_offset <= w_base + 24'd1;
                end else begin
                    r_offset <= w_base;
                end
            end
            if (i_cmd.start) begin
                r_addr  <= w_start_addr;
                r_wide  <= |w_start_addr[23:16];
                r_sum   <= w_start_addr[23:16] + w_start_addr[15:8] + w_start_addr[7:0];
                r_count <= '0;
            end
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.step_idx) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Payload registers: buffer, latched input word and output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_loc    <= i_location;
            if (w_in_data && (r_count < CNT_W'(BYTES_PER_RECORD))) begin
                r_bytes[r_count[BI_W-1:0]] <= i_data_byte;
            end
        end
        if (i_cmd.load) begin
            r_char  <= w_char;
            r_last  <= i_cmd.last;
            r_error <= (i_cmd.sel == CS_ERR);
        end
    end

endmodule

### rtl/s_record_object_encoder_unit.sv
// S-record object encoder: one byte or command word in, ASCII record text out.
// A data byte that does not fill a record sends no characters; any other word is
// decoded and may then send its record or text lines one character at a time.
// A full S1 record of 16 bytes is 43 characters, S2 45, header and trailer 11 each.
// Throughput: one character a cycle from the single output register if not stalled.
// Synchronous active-low reset clears the record state and disables output.
// Depends on sroe_pkg, sroe_ctrl and sroe_dp.
module s_record_object_encoder_unit
    import sroe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic [23:0] i_location,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_out_char,
    output logic        o_last,
    output logic        o_error
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencing controller.
    sroe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Record datapath and output word.
    sroe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_location  (i_location),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_char  (o_out_char),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

### verif/tb.sv
// Self-checking testbench for s_record_object_encoder_unit: drives command and byte words,
// predicts the S-record text in a scoreboard class and checks every character word.
// Depends on sroe_pkg and the encoder RTL only.
module tb
    import sroe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Action codes the package leaves unnamed: both are rejected by the block.
    localparam logic [2:0] ACT_BAD_LO = 3'd6;
    localparam logic [2:0] ACT_BAD_HI = 3'd7;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;

    // One expected character word.
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       err;
    } t_srec_char;

    // Predicts the record text from each accepted word and checks the character words.
    class t_char_board;
        bit [7:0]   rec_bytes [16];
        bit [4:0]   n_bytes;
        bit [7:0]   csum;
        bit [23:0]  offset;
        bit [23:0]  rec_addr;
        bit         wide;
        bit         enabled;
        t_srec_char due_chars [$];
        t_srec_char word_chars [$];
        int         n_bad;
        int         n_checked;
        int         n_records;
        int         n_fixed;
        int         n_errors;

        function bit [6:0] hex_digit(bit [3:0] v);
            return (v < 4'd10) ? 7'h30 + 7'(v) : 7'h37 + 7'(v);
        endfunction

        function void put_char(bit [6:0] ch);
            t_srec_char c;
            c.ch   = ch;
            c.last = 1'b0;
            c.err  = 1'b0;
            word_chars.push_back(c);
        endfunction

        function void put_hex(bit [7:0] b);
            put_char(hex_digit(b[7:4]));
            put_char(hex_digit(b[3:0]));
        endfunction

        function void put_text(string s);
            byte c;
            for (int i = 0; i < s.len(); i++) begin
                c = s[i];
                put_char(c[6:0]);
            end
        endfunction

        // A new record takes its address now; the address bytes seed the checksum.
        function void begin_record(bit [23:0] addr);
            rec_addr = addr;
            wide     = |addr[23:16];
            csum     = addr[23:16] + addr[15:8] + addr[7:0];
            n_bytes  = '0;
        endfunction

        // Empty records produce no text at all.
        function void flush_record();
            bit [7:0] total;
            bit [7:0] sum;
            if (n_bytes == 0) return;
            total = 8'(n_bytes) + (wide ? 8'd4 : 8'd3);
            put_char(CH_S);
            put_char(wide ? CH_2 : CH_1);
            put_hex(total);
            if (wide) put_hex(rec_addr[23:16]);
            put_hex(rec_addr[15:8]);
            put_hex(rec_addr[7:0]);
            for (int i = 0; i < n_bytes; i++) put_hex(rec_bytes[i]);
            sum = csum + total;
            put_hex(8'hFF - sum);
            put_char(CH_NL);
            n_records++;
        endfunction

        // Works out the characters that one accepted word causes and queues them.
        function void note_word(bit [2:0] act, bit [7:0] b, bit [23:0] loc);
            t_srec_char tail;
            if (!enabled) return;
            word_chars.delete();
            case (act) inside
                ACT_DATA, ACT_FIRST: begin
                    if (act == ACT_FIRST) offset = '0;
                    if (n_bytes < BYTES_PER_RECORD) begin
                        rec_bytes[n_bytes[3:0]] = b;
                        csum += b;
                        n_bytes++;
                        offset++;
                    end
                    if (n_bytes >= BYTES_PER_RECORD) begin
                        flush_record();
                        begin_record(loc + offset);
                    end
                end
                ACT_SYNC: begin
                    flush_record();
                    begin_record(loc);
                end
                ACT_OPEN: begin
                    put_text("S0030000FC\n");
                    n_fixed++;
                    begin_record(loc);
                end
                ACT_CLOSE: begin
                    flush_record();
                    begin_record(loc);
                    put_text("S9030000FC\n");
                    n_fixed++;
                end
                ACT_MSG: begin
                end
                default: begin
                    tail.ch   = CH_NUL;
                    tail.last = 1'b1;
                    tail.err  = 1'b1;
                    word_chars.push_back(tail);
                    n_errors++;
                end
            endcase
            if (word_chars.size() > 0) begin
                tail = word_chars.pop_back();
                tail.last = 1'b1;
                word_chars.push_back(tail);
            end
            foreach (word_chars[i]) due_chars.push_back(word_chars[i]);
        endfunction

        // Compares one accepted character word with the oldest expectation.
        function void check_char(logic [6:0] ch, logic last, logic err);
            t_srec_char want;
            n_checked++;
            if (due_chars.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("tb: unexpected character %h (last %b, error %b)", ch, last, err);
                return;
            end
            want = due_chars.pop_front();
            if (want.ch !== ch || want.last !== last || want.err !== err) begin
                n_bad++;
                if (n_bad <= 10)
                    $display({"tb: character %0d expected %h last %b error %b,",
                              " got %h last %b error %b"},
                             n_checked, want.ch, want.last, want.err, ch, last, err);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic [23:0] location;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  out_char;
    logic        out_last;
    logic        out_error;

    bit          quiet;
    bit          hold_req;
    int          cycles;
    int          words_sent;
    t_char_board sb;

    s_record_object_encoder_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_action    (action),
        .i_data_byte (data_byte),
        .i_location  (location),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_char  (out_char),
        .o_last      (out_last),
        .o_error     (out_error)
    );

    // 12 ns clock.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Cycle limit: a hung block ends the run here.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d characters still due",
                     cycles, sb.due_chars.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Every accepted character word is checked at the clock edge that takes it.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_char(out_char, out_last, out_error);
        end
    end

    // Receiver: random stall bursts, one long hold on request, none in the quiet part.
    initial begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    // Offers one word, sometimes after a random gap, and waits until it is taken.
    task automatic send_word(input logic [2:0] act, input logic [7:0] b, input logic [23:0] loc);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= b;
        location  <= loc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(act, b, loc);
        words_sent++;
    endtask

    // Stops offering and waits until every expected character has arrived and the
    // block has had time to finish a byte that caused none.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.due_chars.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Writes the output enable register; the block must be idle.
    task automatic write_enable(input logic v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.enabled = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Locations favour the S1/S2 boundary and the top of the 24-bit space.
    function automatic logic [23:0] pick_location();
        logic [23:0] loc;
        case ($urandom_range(0, 4))
            0:       loc = 24'($urandom_range(0, 16'hFFFF));
            1:       loc = 24'($urandom_range(24'h00FFF0, 24'h01000F));
            2:       loc = 24'($urandom_range(24'hFFFFE0, 24'hFFFFFF));
            3:       loc = 24'h000000;
            default: loc = 24'($urandom);
        endcase
        return loc;
    endfunction

    // Mostly runs of data bytes between syncs, opens and closes; some noise words.
    task automatic random_traffic(input int n_words);
        int          sent;
        int          len;
        int          pick;
        logic [23:0] loc;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(0, 99);
            loc  = pick_location();
            if (pick < 60) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 16);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 7) == 0) loc = pick_location();
                    send_word((i == 0) ? ACT_FIRST : ACT_DATA, 8'($urandom), loc);
                end
                sent += len;
            end else if (pick < 70) begin
                send_word(ACT_SYNC, 8'($urandom), loc);
                sent++;
            end else if (pick < 76) begin
                send_word(ACT_OPEN, 8'($urandom), loc);
                sent++;
            end else if (pick < 82) begin
                send_word(ACT_CLOSE, 8'($urandom), loc);
                sent++;
            end else if (pick < 88) begin
                send_word(ACT_MSG, 8'($urandom), loc);
                sent++;
            end else if (pick < 93) begin
                send_word($urandom_range(0, 1) ? ACT_BAD_HI : ACT_BAD_LO, 8'($urandom), loc);
                sent++;
            end else begin
                send_word(3'($urandom), 8'($urandom), 24'($urandom));
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed words, random phases with the output toggled off
    // once, and a final stretch with no idling on either side.
    initial begin
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_DATA;
        data_byte = 8'h00;
        location  = 24'h000000;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        write_enable(1'b1);

        // Data before any open goes to address zero in S1 form.
        send_word(ACT_FIRST, 8'h00, 24'h000000);
        send_word(ACT_DATA, 8'hFF, 24'h000000);
        send_word(ACT_MSG, 8'h5A, 24'hABCDEF);
        send_word(ACT_BAD_LO, 8'h00, 24'h000000);
        send_word(ACT_BAD_HI, 8'hFF, 24'hFFFFFF);
        // Sync flushes the S1 record; a second sync finds it empty and emits nothing.
        send_word(ACT_SYNC, 8'h00, 24'hFFFFF0);
        send_word(ACT_SYNC, 8'h00, 24'hFFFFF0);
        // A full record after open; the next address wraps past the top of the space.
        send_word(ACT_OPEN, 8'h00, 24'h00FFFF);
        for (int i = 0; i < 16; i++) begin
            send_word((i == 0) ? ACT_FIRST : ACT_DATA,
                      i[0] ? ~(8'(i) * 8'h11) : 8'(i) * 8'h11, 24'hFFFFF8);
        end
        send_word(ACT_DATA, 8'h81, 24'h7FFFFF);
        send_word(ACT_CLOSE, 8'h00, 24'h123456);

        random_traffic(50);
        hold_req = 1'b1;
        random_traffic(80);

        // With the output disabled nothing comes out and the record state is kept.
        drain();
        write_enable(1'b0);
        random_traffic(20);
        drain();
        write_enable(1'b1);

        random_traffic(80);
        quiet = 1'b1;
        random_traffic(50);
        drain();

        $display("tb: %0d words sent; %0d data records, %0d header/trailer lines, %0d rejected",
                 words_sent, sb.n_records, sb.n_fixed, sb.n_errors);
        $display("tb: %0d characters checked, %0d mismatches", sb.n_checked, sb.n_bad);
        if (sb.n_bad == 0 && sb.due_chars.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/sroe_pkg.sv
rtl/sroe_ctrl.sv
rtl/sroe_dp.sv
rtl/s_record_object_encoder_unit.sv
verif/tb.sv
